>>> hdl/svga_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the state vector gate unit
// no dependencies

package svga_pkg;

    localparam int MAX_QUBITS = 10;
    localparam int AMP_BITS   = 16;
    localparam int IDX_BITS   = MAX_QUBITS;
    localparam int PAIR_BITS  = MAX_QUBITS - 1;
    localparam int NQ_BITS    = 4;
    localparam int WORD_BITS  = 2 * AMP_BITS;
    localparam int PROD_BITS  = 2 * AMP_BITS;
    localparam int RND_BITS   = AMP_BITS + 1;
    localparam int SUM_BITS   = RND_BITS + 2;

    localparam logic [1:0] MODE_RELOAD = 2'd0;
    localparam logic [1:0] MODE_GATE   = 2'd1;
    localparam logic [1:0] MODE_CNOT   = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // byte address of the qubit count register
    localparam logic [1:0] REG_QCOUNT  = 2'd0;

    localparam logic [AMP_BITS-1:0] AMP_ONE = {1'b0, {(AMP_BITS-1){1'b1}}};

    typedef struct packed {
        logic [1:0]                 mode;
        logic [3:0]                 target;
        logic [3:0]                 control;
        logic [IDX_BITS-1:0]        index;
        logic signed [AMP_BITS-1:0] u00_re;
        logic signed [AMP_BITS-1:0] u00_im;
        logic signed [AMP_BITS-1:0] u01_re;
        logic signed [AMP_BITS-1:0] u01_im;
        logic signed [AMP_BITS-1:0] u10_re;
        logic signed [AMP_BITS-1:0] u10_im;
        logic signed [AMP_BITS-1:0] u11_re;
        logic signed [AMP_BITS-1:0] u11_im;
    } svga_op_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]        read_index;
        logic signed [AMP_BITS-1:0] amp_re;
        logic signed [AMP_BITS-1:0] amp_im;
    } svga_res_t;

    // pair in flight: bank 0 / bank 1 addresses and how to write it back
    typedef struct packed {
        logic                 vld;
        logic                 swp;
        logic                 wen;
        logic                 par;
        logic [PAIR_BITS-1:0] addr0;
        logic [PAIR_BITS-1:0] addr1;
    } svga_tag_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GATE,
        ST_DRAIN,
        ST_RD_ISSUE,
        ST_RD_DATA
    } svga_state_t;

    // round half up to the amplitude format
    function automatic logic signed [RND_BITS-1:0] rnd_prod(input logic signed [PROD_BITS-1:0] p);
        logic signed [PROD_BITS-1:0] s;
        s = p + PROD_BITS'(1 << (AMP_BITS - 2));
        return s[PROD_BITS-1:AMP_BITS-1];
    endfunction

    function automatic logic signed [AMP_BITS-1:0] sat_amp(input logic signed [SUM_BITS-1:0] s);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'(AMP_ONE);
        lo = -hi - SUM_BITS'(1);
        if (s > hi)
            return AMP_ONE;
        else if (s < lo)
            return ~AMP_ONE;
        else
            return s[AMP_BITS-1:0];
    endfunction

endpackage

>>> hdl/state_vector_gate_apply_unit.sv
`timescale 1ns / 1ps
// top level of the state vector gate unit: control, two amplitude banks, ports
// uses svga_pkg and svga_pair_dp

// The state of 2^n complex amplitudes lives in two 512-word banks, split by the
// parity of the basis index, so both members of any pair are read and written in
// the same cycle. A gate or CNOT streams one pair per cycle through the pair
// datapath and holds the input until the datapath has drained; a read passes
// through an issue and a data state, waiting while an earlier result is held; a
// reload, an APB write in the idle state and reset each run a clearing pass over
// all 512 words of the banks, during which no word is taken (op_stall high).

module state_vector_gate_apply_unit import svga_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   op_valid,
    output logic                   op_stall,
    input  svga_op_t               op_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output svga_res_t              res_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    svga_state_t               state_reg, state_next;
    logic [NQ_BITS-1:0]        nq_reg;
    logic [NQ_BITS-1:0]        n_used;
    svga_op_t                  op_reg;
    logic [PAIR_BITS-1:0]      cnt_reg, cnt_next;
    logic [PAIR_BITS-1:0]      pair_mask;
    svga_tag_t                 tag1_reg, tag1_next;
    svga_tag_t                 wtag;
    logic                      cfg_wr;
    logic                      op_acc;
    logic                      gate_ok, cnot_ok;
    logic                      res_valid_reg;
    svga_res_t                 res_reg;

    logic [WORD_BITS-1:0]      bank0 [1 << PAIR_BITS];
    logic [WORD_BITS-1:0]      bank1 [1 << PAIR_BITS];
    logic [WORD_BITS-1:0]      rd0_reg, rd1_reg;
    logic [PAIR_BITS-1:0]      ra0, ra1, wa0, wa1;
    logic [WORD_BITS-1:0]      wd0, wd1;
    logic                      we0, we1;
    logic [WORD_BITS-1:0]      a_rd, b_rd, a_wr, b_wr;
    logic                      dp_busy;

    logic [IDX_BITS-1:0]       kk, low_mask, idx_i, idx_j;
    logic [IDX_BITS:0]         rd_hi;
    logic [WORD_BITS-1:0]      rd_word;

    assign pready = 1'b1;
    assign prdata = {{(32-NQ_BITS){1'b0}}, nq_reg};
    assign cfg_wr = psel & penable & pwrite;
    assign op_acc = op_valid & ~op_stall;

    always_comb
    begin
        if (nq_reg == '0)
            n_used = NQ_BITS'(1);
        else if (nq_reg > NQ_BITS'(MAX_QUBITS))
            n_used = NQ_BITS'(MAX_QUBITS);
        else
            n_used = nq_reg;
    end

    assign pair_mask = (PAIR_BITS'(1) << (n_used - NQ_BITS'(1))) - PAIR_BITS'(1);
    assign gate_ok   = op_data.target < n_used;
    assign cnot_ok   = gate_ok && (op_data.control < n_used) && (op_data.control != op_data.target);

    // pair k -> low index with a zero inserted at the target bit
    assign kk       = {1'b0, cnt_reg};
    assign low_mask = (IDX_BITS'(1) << op_reg.target) - IDX_BITS'(1);
    assign idx_i    = ((kk & ~low_mask) << 1) | (kk & low_mask);
    assign idx_j    = idx_i | (IDX_BITS'(1) << op_reg.target);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (cnt_reg == '1)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (cfg_wr)
                    state_next = ST_CLEAR;
                else if (op_valid)
                begin
                    case (op_data.mode)
                        MODE_RELOAD: state_next = ST_CLEAR;
                        MODE_GATE:   state_next = gate_ok ? ST_GATE : ST_IDLE;
                        MODE_CNOT:   state_next = cnot_ok ? ST_GATE : ST_IDLE;
                        MODE_READ:   state_next = ST_RD_ISSUE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            ST_GATE:
                if (cnt_reg == pair_mask)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!tag1_reg.vld && !dp_busy)
                    state_next = ST_IDLE;
            ST_RD_ISSUE:
                if (!res_valid_reg)
                    state_next = ST_RD_DATA;
            ST_RD_DATA:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        op_stall  = (state_reg != ST_IDLE);
        cnt_next  = '0;
        tag1_next = '0;
        ra0       = idx_i[IDX_BITS-1:1];
        ra1       = idx_j[IDX_BITS-1:1];
        if (^idx_i)
        begin
            ra0 = idx_j[IDX_BITS-1:1];
            ra1 = idx_i[IDX_BITS-1:1];
        end
        case (state_reg)
            ST_CLEAR:
                cnt_next = cnt_reg + PAIR_BITS'(1);
            ST_GATE:
            begin
                cnt_next        = cnt_reg + PAIR_BITS'(1);
                tag1_next.vld   = 1'b1;
                tag1_next.swp   = (op_reg.mode == MODE_CNOT);
                tag1_next.wen   = (op_reg.mode != MODE_CNOT) || idx_i[op_reg.control];
                tag1_next.par   = ^idx_i;
                tag1_next.addr0 = ra0;
                tag1_next.addr1 = ra1;
            end
            ST_RD_ISSUE:
            begin
                ra0 = op_reg.index[IDX_BITS-1:1];
                ra1 = op_reg.index[IDX_BITS-1:1];
            end
            default:
                cnt_next = '0;
        endcase
    end

    assign a_rd = tag1_reg.par ? rd1_reg : rd0_reg;
    assign b_rd = tag1_reg.par ? rd0_reg : rd1_reg;

    svga_pair_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag1_reg),
        .a_in    (a_rd),
        .b_in    (b_rd),
        .mat     (op_reg),
        .tag_out (wtag),
        .a_out   (a_wr),
        .b_out   (b_wr),
        .busy    (dp_busy)
    );

    // write port: clearing pass or pair write back
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            we0 = 1'b1;
            we1 = 1'b1;
            wa0 = cnt_reg;
            wa1 = cnt_reg;
            wd0 = (cnt_reg == '0) ? {AMP_ONE, {AMP_BITS{1'b0}}} : '0;
            wd1 = '0;
        end
        else
        begin
            we0 = wtag.vld & wtag.wen;
            we1 = wtag.vld & wtag.wen;
            wa0 = wtag.addr0;
            wa1 = wtag.addr1;
            wd0 = wtag.par ? b_wr : a_wr;
            wd1 = wtag.par ? a_wr : b_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we0)
            bank0[wa0] <= wd0;
        rd0_reg <= bank0[ra0];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
            bank1[wa1] <= wd1;
        rd1_reg <= bank1[ra1];
    end

    // read result, zero beyond the active state size
    assign rd_hi   = {1'b0, op_reg.index} >> n_used;
    assign rd_word = (^op_reg.index) ? rd1_reg : rd0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            nq_reg        <= NQ_BITS'(1);
            cnt_reg       <= '0;
            tag1_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tag1_reg  <= tag1_next;
            if (cfg_wr && paddr == REG_QCOUNT)
                nq_reg <= pwdata[NQ_BITS-1:0];
            if (state_reg == ST_RD_DATA)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_acc)
            op_reg <= op_data;
        if (state_reg == ST_RD_DATA)
        begin
            res_reg.read_index <= op_reg.index;
            if (rd_hi == '0)
            begin
                res_reg.amp_re <= rd_word[WORD_BITS-1:AMP_BITS];
                res_reg.amp_im <= rd_word[AMP_BITS-1:0];
            end
            else
            begin
                res_reg.amp_re <= '0;
                res_reg.amp_im <= '0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

>>> hdl/svga_pair_dp.sv
`timescale 1ns / 1ps
// pair datapath: 2x2 complex matrix times an amplitude pair, or a plain swap
// two register stages (products, rounded sums); uses svga_pkg

module svga_pair_dp import svga_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  svga_tag_t              tag_in,
    input  logic [WORD_BITS-1:0]   a_in,
    input  logic [WORD_BITS-1:0]   b_in,
    input  svga_op_t               mat,
    output svga_tag_t              tag_out,
    output logic [WORD_BITS-1:0]   a_out,
    output logic [WORD_BITS-1:0]   b_out,
    output logic                   busy
);

    svga_tag_t                    tag2_reg;
    svga_tag_t                    tag3_reg;
    logic signed [PROD_BITS-1:0]  prod_reg [16];
    logic signed [PROD_BITS-1:0]  prod_next [16];
    logic [WORD_BITS-1:0]         a2_reg;
    logic [WORD_BITS-1:0]         b2_reg;
    logic [WORD_BITS-1:0]         a3_reg;
    logic [WORD_BITS-1:0]         b3_reg;
    logic [WORD_BITS-1:0]         a3_next;
    logic [WORD_BITS-1:0]         b3_next;
    logic signed [AMP_BITS-1:0]   ar, ai, br, bi;
    logic signed [RND_BITS-1:0]   r [16];
    logic signed [SUM_BITS-1:0]   s [4];

    assign ar = a_in[WORD_BITS-1:AMP_BITS];
    assign ai = a_in[AMP_BITS-1:0];
    assign br = b_in[WORD_BITS-1:AMP_BITS];
    assign bi = b_in[AMP_BITS-1:0];

    // product order per part: u*a_x, u*a_y, v*b_x, v*b_y
    always_comb
    begin
        prod_next[0]  = mat.u00_re * ar;
        prod_next[1]  = mat.u00_im * ai;
        prod_next[2]  = mat.u01_re * br;
        prod_next[3]  = mat.u01_im * bi;
        prod_next[4]  = mat.u00_re * ai;
        prod_next[5]  = mat.u00_im * ar;
        prod_next[6]  = mat.u01_re * bi;
        prod_next[7]  = mat.u01_im * br;
        prod_next[8]  = mat.u10_re * ar;
        prod_next[9]  = mat.u10_im * ai;
        prod_next[10] = mat.u11_re * br;
        prod_next[11] = mat.u11_im * bi;
        prod_next[12] = mat.u10_re * ai;
        prod_next[13] = mat.u10_im * ar;
        prod_next[14] = mat.u11_re * bi;
        prod_next[15] = mat.u11_im * br;
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
            r[k] = rnd_prod(prod_reg[k]);
        s[0] = SUM_BITS'(r[0]) - SUM_BITS'(r[1]) + SUM_BITS'(r[2]) - SUM_BITS'(r[3]);
        s[1] = SUM_BITS'(r[4]) + SUM_BITS'(r[5]) + SUM_BITS'(r[6]) + SUM_BITS'(r[7]);
        s[2] = SUM_BITS'(r[8]) - SUM_BITS'(r[9]) + SUM_BITS'(r[10]) - SUM_BITS'(r[11]);
        s[3] = SUM_BITS'(r[12]) + SUM_BITS'(r[13]) + SUM_BITS'(r[14]) + SUM_BITS'(r[15]);
        if (tag2_reg.swp)
        begin
            a3_next = b2_reg;
            b3_next = a2_reg;
        end
        else
        begin
            a3_next = {sat_amp(s[0]), sat_amp(s[1])};
            b3_next = {sat_amp(s[2]), sat_amp(s[3])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a2_reg   <= a_in;
        b2_reg   <= b_in;
        a3_reg   <= a3_next;
        b3_reg   <= b3_next;
    end

    assign tag_out = tag3_reg;
    assign a_out   = a3_reg;
    assign b_out   = b3_reg;
    assign busy    = tag2_reg.vld | tag3_reg.vld;

endmodule

>>> hdl/svga_checker.sv
`timescale 1ns / 1ps
// port-level checks of the state vector gate unit, bound to the top level
// uses svga_pkg

module svga_checker import svga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  logic        op_stall,
    input  svga_op_t    op_data,
    input  logic        res_valid,
    input  logic        res_stall,
    input  svga_res_t   res_data
);

    // held result word stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result word changed while stalled");

    // no word taken while reset is asserted
    a_rst_stall: assert property (@(posedge clk) !rst_n |-> op_stall)
        else $error("input open during reset");

    // reload starts a clearing pass
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_stall && op_data.mode == MODE_RELOAD |=> op_stall)
        else $error("reload did not block input");

    // a read taken with a free result slot is answered with a valid result carrying its index
    a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_stall && op_data.mode == MODE_READ && !res_valid
        |-> ##3 res_valid && res_data.read_index == $past(op_data.index, 3))
        else $error("read result late or wrong index");

endmodule

bind state_vector_gate_apply_unit svga_checker u_svga_checker (.*);
